@@ design/led_pkg.sv @@
package led_pkg;

	// Width of one string character.
	localparam int unsigned CharW = 8;

	// Width of the distance field on the result stream.
	localparam int unsigned DistW = 7;

	// Operation codes carried in the lowest bit of the input tuser.
	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// Control and character of one wavefront moving down the cell chain.
	typedef struct packed {
		logic             valid;
		logic             last;  // wave closes a query and yields a result
		logic             upd;   // wave updates the cost row
		logic             fix;   // result is fixed at entry, cells leave it alone
		logic             tl;    // too-long flag of the result
		logic [CharW-1:0] ch;    // query character
	} wave_t;

endpackage

@@ design/led_cell.sv @@
module led_cell #(
	parameter int unsigned LW  = 7,
	parameter int unsigned IW  = 6,
	parameter int unsigned IDX = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          init,
	input  logic                          ld_we,
	input  logic [IW-1:0]                 ld_idx,
	input  logic [led_pkg::CharW-1:0]     ld_char,
	input  logic [LW-1:0]                 ref_len,
	input  led_pkg::wave_t                wave_in,
	input  logic [LW-1:0]                 left_in,
	input  logic [LW-1:0]                 diag_in,
	input  logic [LW-1:0]                 res_in,
	output led_pkg::wave_t                wave_out,
	output logic [LW-1:0]                 left_out,
	output logic [LW-1:0]                 diag_out,
	output logic [LW-1:0]                 res_out
);

	logic [led_pkg::CharW-1:0] ch_q;
	logic [LW-1:0]             cost_q;
	led_pkg::wave_t            wave_q;
	logic [LW-1:0]             left_q;
	logic [LW-1:0]             diag_q;
	logic [LW-1:0]             res_q;

	logic          act;
	logic          mism;
	logic [LW:0]   up1;
	logic [LW:0]   lf1;
	logic [LW:0]   sub;
	logic [LW:0]   m1;
	logic [LW:0]   m2;
	logic [LW-1:0] new_cost;
	logic [LW-1:0] res_nxt;

	// This cell holds column IDX of the cost row and reference character IDX-1.
	assign act  = (LW'(IDX) <= ref_len);
	assign mism = (ch_q != wave_in.ch);
	assign up1  = {1'b0, cost_q} + (LW+1)'(1);
	assign lf1  = {1'b0, left_in} + (LW+1)'(1);
	assign sub  = {1'b0, diag_in} + (LW+1)'(mism);

	always_comb begin
		m1       = (up1 < lf1) ? up1 : lf1;
		m2       = (m1 < sub) ? m1 : sub;
		new_cost = LW'(m2);
		if (wave_in.fix || !act) begin
			res_nxt = res_in;
		end else if (wave_in.upd) begin
			res_nxt = new_cost;
		end else begin
			res_nxt = cost_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_we && (ld_idx == IW'(IDX - 1))) begin
			ch_q <= ld_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q <= '0;
		end else if (init) begin
			cost_q <= LW'(IDX);
		end else if (en && wave_in.valid && wave_in.upd && act) begin
			cost_q <= new_cost;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else if (en) begin
			wave_q <= wave_in;
		end
	end

	// The old cost goes on as the diagonal term of the next column.
	always_ff @(posedge clk) begin
		if (en) begin
			left_q <= new_cost;
			diag_q <= cost_q;
			res_q  <= res_nxt;
		end
	end

	assign wave_out = wave_q;
	assign left_out = left_q;
	assign diag_out = diag_q;
	assign res_out  = res_q;

endmodule

@@ design/levenshtein_edit_distance.sv @@
// Levenshtein edit distance engine with unit insert, delete and substitute costs.
// Input stream s_axis: tdata carries one character, tlast marks the final character
// of a string, tuser[0] selects load (0) or query (1), tuser[1] flags an empty string.
// Load transfers build the reference one character at a time. Query transfers stream
// the query; each character enters a chain of MAX_LEN cells, one column per cell,
// and moves one cell per cycle as a diagonal wavefront unless the result side stalls.
// While a query streams and the result side does not stall, one character is taken
// every cycle, dropped characters of a long query included. A load and the first
// character of a new query wait until the chain has drained.
// The result of a query appears on m_axis after its final character has passed the entry
// stage, every cell and the output register; tdata holds the distance, tuser the too-long flag.
// When the result receiver stalls, the whole chain holds and s_axis_tready drops.
// Reset clears the reference length, the query state and the chain; reference
// characters are undefined until loaded.
module levenshtein_edit_distance #(
	parameter int unsigned MAX_LEN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_code
	input  logic       s_axis_tlast,
	input  logic [1:0] s_axis_tuser,   // [0] operation, [1] is_empty
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [6:0] distance, [7] zero
	output logic       m_axis_tuser    // [0] too_long
);

	localparam int unsigned LW = $clog2(MAX_LEN + 1);
	localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	led_pkg::wave_t wave [0:MAX_LEN];
	logic [LW-1:0]  left_w [0:MAX_LEN];
	logic [LW-1:0]  diag_w [0:MAX_LEN];
	logic [LW-1:0]  res_w [0:MAX_LEN];
	logic [MAX_LEN:0] valid_vec;

	led_pkg::wave_t inj_wave_q;
	logic [LW-1:0]  inj_left_q;
	logic [LW-1:0]  inj_diag_q;
	logic [LW-1:0]  inj_res_q;

	logic [LW-1:0] ref_len_q;
	logic          ref_done_q;
	logic          ref_over_q;
	logic [LW-1:0] qcount_q;
	logic          ovf_q;
	logic          qact_q;

	logic                       out_valid_q;
	logic [led_pkg::DistW-1:0]  out_dist_q;
	logic                       out_tl_q;

	led_pkg::op_t op;
	logic         emp;
	logic         en;
	logic         busy;
	logic         acc;
	logic         start;
	logic [LW-1:0] cnt_base;
	logic [LW-1:0] cnt_inc;
	logic          ovf_base;
	logic          room;
	logic [LW-1:0] len_base;
	logic          over_base;
	logic          len_room;
	logic          ld_we;
	logic          fin_last;

	assign op       = led_pkg::op_t'(s_axis_tuser[0]);
	assign emp      = s_axis_tuser[1];
	assign en       = !out_valid_q || m_axis_tready;
	assign busy     = |valid_vec;
	// Only further characters of a running query, or an empty query, may follow
	// waves still in the chain; everything else waits for the chain to drain.
	assign s_axis_tready = en && (!busy || ((op == led_pkg::OP_QUERY) && (emp || qact_q)));
	assign acc      = s_axis_tvalid && s_axis_tready;
	assign start    = acc && (op == led_pkg::OP_QUERY) && !emp && !qact_q;

	assign cnt_base  = qact_q ? qcount_q : '0;
	assign ovf_base  = qact_q ? ovf_q : 1'b0;
	assign room      = (cnt_base < LW'(MAX_LEN));
	assign cnt_inc   = cnt_base + LW'(1);
	assign len_base  = ref_done_q ? '0 : ref_len_q;
	assign over_base = ref_done_q ? 1'b0 : ref_over_q;
	assign len_room  = (len_base < LW'(MAX_LEN));
	assign ld_we     = acc && (op == led_pkg::OP_LOAD) && !emp && len_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_len_q  <= '0;
			ref_done_q <= 1'b0;
			ref_over_q <= 1'b0;
			qcount_q   <= '0;
			ovf_q      <= 1'b0;
			qact_q     <= 1'b0;
		end else if (acc) begin
			case (op)
				led_pkg::OP_LOAD: begin
					qact_q   <= 1'b0;
					qcount_q <= '0;
					ovf_q    <= 1'b0;
					if (emp) begin
						ref_len_q  <= '0;
						ref_over_q <= 1'b0;
						ref_done_q <= 1'b1;
					end else begin
						ref_done_q <= s_axis_tlast;
						if (len_room) begin
							ref_len_q  <= len_base + LW'(1);
							ref_over_q <= over_base;
						end else begin
							ref_len_q  <= len_base;
							ref_over_q <= 1'b1;
						end
					end
				end
				led_pkg::OP_QUERY: begin
					if (emp) begin
						qact_q   <= 1'b0;
						qcount_q <= '0;
						ovf_q    <= 1'b0;
					end else begin
						qact_q   <= !s_axis_tlast;
						qcount_q <= room ? cnt_inc : cnt_base;
						ovf_q    <= ovf_base || !room;
					end
				end
				default: begin
					qact_q <= qact_q;
				end
			endcase
		end
	end

	// Entry stage: the wave carries column zero of the new row (the query count).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_wave_q <= '0;
		end else if (en) begin
			inj_wave_q.valid <= acc && (op == led_pkg::OP_QUERY);
			inj_wave_q.last  <= emp || s_axis_tlast;
			inj_wave_q.upd   <= !emp && room;
			inj_wave_q.fix   <= emp;
			inj_wave_q.tl    <= emp ? ref_over_q : (ovf_base || !room || ref_over_q);
			inj_wave_q.ch    <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inj_left_q <= cnt_inc;
			inj_diag_q <= cnt_base;
			if (emp) begin
				inj_res_q <= ref_len_q;
			end else begin
				inj_res_q <= room ? cnt_inc : cnt_base;
			end
		end
	end

	assign wave[0]   = inj_wave_q;
	assign left_w[0] = inj_left_q;
	assign diag_w[0] = inj_diag_q;
	assign res_w[0]  = inj_res_q;

	for (genvar k = 0; k <= MAX_LEN; k++) begin : g_vld
		assign valid_vec[k] = wave[k].valid;
	end

	for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
		led_cell #(
			.LW  (LW),
			.IW  (IW),
			.IDX (j)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.init     (start),
			.ld_we    (ld_we),
			.ld_idx   (IW'(len_base)),
			.ld_char  (s_axis_tdata),
			.ref_len  (ref_len_q),
			.wave_in  (wave[j-1]),
			.left_in  (left_w[j-1]),
			.diag_in  (diag_w[j-1]),
			.res_in   (res_w[j-1]),
			.wave_out (wave[j]),
			.left_out (left_w[j]),
			.diag_out (diag_w[j]),
			.res_out  (res_w[j])
		);
	end

	assign fin_last = wave[MAX_LEN].valid && wave[MAX_LEN].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= fin_last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_dist_q <= led_pkg::DistW'(res_w[MAX_LEN]);
			out_tl_q   <= wave[MAX_LEN].tl;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_dist_q};
	assign m_axis_tuser  = out_tl_q;

	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (op == led_pkg::OP_LOAD)) |-> !busy)
		else $error("load transfer taken while waves are in the chain");

	a_qcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		qcount_q <= LW'(MAX_LEN))
		else $error("query count beyond maximum length");

	a_reflen_range: assert property (@(posedge clk) disable iff (!arst_n)
		ref_len_q <= LW'(MAX_LEN))
		else $error("reference length beyond maximum length");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fin_last))
		else $error("result raised without a closing wave at the chain end");

endmodule

@@ sim/levenshtein_checker.sv @@
`timescale 1ns / 100ps

module levenshtein_checker #(
	parameter int unsigned MAX_LEN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_code
	input  logic       s_axis_tlast,
	input  logic [1:0] s_axis_tuser,   // [0] operation, [1] is_empty
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,   // [6:0] distance, [7] zero
	input  logic       m_axis_tuser,   // [0] too_long
	output int         errors,
	output int         pending,
	output int         items_seen,
	output int         results_seen,
	output int         long_results
);

	typedef struct packed {
		logic [led_pkg::DistW-1:0] distance;
		logic                      too_long;
	} edit_result_t;

	edit_result_t              result_fifo [$];
	edit_result_t              want;
	logic [led_pkg::CharW-1:0] ref_bytes [MAX_LEN];
	int unsigned               ref_len;
	bit                        ref_complete;
	bit                        ref_long;
	int unsigned               cost_row [MAX_LEN + 1];
	int unsigned               q_len;
	bit                        q_long;
	bit                        q_open;
	int                        err_count;
	int                        n_items;
	int                        n_results;
	int                        n_long;

	task automatic push_result(input int unsigned dist_val, input bit too_long);
		edit_result_t r;
		if (dist_val > MAX_LEN)
			dist_val = MAX_LEN;
		r.distance = dist_val[led_pkg::DistW-1:0];
		r.too_long = too_long;
		result_fifo.push_back(r);
	endtask

	// Advances the distance engine by one accepted input transfer.
	task automatic apply_item(input led_pkg::op_t op, input logic [led_pkg::CharW-1:0] ch,
			input logic last, input logic empty);
		int unsigned j;
		int unsigned diag;
		int unsigned up;
		int unsigned sub;
		int unsigned best;
		if (op == led_pkg::OP_LOAD) begin
			// Any load drops a query in progress without a result.
			q_open = 1'b0;
			q_len = 0;
			q_long = 1'b0;
			if (ref_complete) begin
				ref_len = 0;
				ref_long = 1'b0;
				ref_complete = 1'b0;
			end
			if (empty) begin
				ref_len = 0;
				ref_long = 1'b0;
				ref_complete = 1'b1;
			end else begin
				if (ref_len < MAX_LEN) begin
					ref_bytes[ref_len] = ch;
					ref_len++;
				end else
					ref_long = 1'b1;
				if (last)
					ref_complete = 1'b1;
			end
		end else if (empty) begin
			q_open = 1'b0;
			q_len = 0;
			q_long = 1'b0;
			push_result(ref_len, ref_long);
		end else begin
			if (!q_open) begin
				for (j = 0; j <= ref_len; j++)
					cost_row[j] = j;
				q_len = 0;
				q_long = 1'b0;
				q_open = 1'b1;
			end
			if (q_len < MAX_LEN) begin
				diag = cost_row[0];
				cost_row[0] = q_len + 1;
				for (j = 1; j <= ref_len; j++) begin
					up = cost_row[j];
					sub = diag + ((ref_bytes[j-1] != ch) ? 1 : 0);
					best = up + 1;
					if (cost_row[j-1] + 1 < best)
						best = cost_row[j-1] + 1;
					if (sub < best)
						best = sub;
					cost_row[j] = best;
					diag = up;
				end
				q_len++;
			end else
				q_long = 1'b1;
			if (last) begin
				push_result(cost_row[ref_len], q_long || ref_long);
				q_open = 1'b0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_fifo.delete();
			for (int i = 0; i < MAX_LEN; i++)
				ref_bytes[i] = '0;
			for (int i = 0; i <= MAX_LEN; i++)
				cost_row[i] = 0;
			ref_len = 0;
			ref_complete = 1'b0;
			ref_long = 1'b0;
			q_len = 0;
			q_long = 1'b0;
			q_open = 1'b0;
			err_count = 0;
			n_items = 0;
			n_results = 0;
			n_long = 0;
		end else begin
			// Results trail their query through the entry stage and the cell chain, so an output
			// transfer never belongs to the input transfer of the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_fifo.size() == 0) begin
					if (err_count < 10)
						$display("unexpected result: distance %0d too_long %0b",
							m_axis_tdata[led_pkg::DistW-1:0], m_axis_tuser);
					err_count++;
				end else begin
					want = result_fifo.pop_front();
					if (m_axis_tdata !== {1'b0, want.distance} ||
							m_axis_tuser !== want.too_long) begin
						if (err_count < 10)
							$display({"result %0d: expected distance %0d too_long %0b,",
								" got tdata 0x%02h too_long %0b"},
								n_results, want.distance, want.too_long,
								m_axis_tdata, m_axis_tuser);
						err_count++;
					end
					n_results++;
					if (want.too_long)
						n_long++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				n_items++;
				apply_item(led_pkg::op_t'(s_axis_tuser[0]), s_axis_tdata, s_axis_tlast,
					s_axis_tuser[1]);
			end
		end
		errors <= err_count;
		pending <= result_fifo.size();
		items_seen <= n_items;
		results_seen <= n_results;
		long_results <= n_long;
	end

endmodule

@@ sim/tb_levenshtein_edit_distance.sv @@
`timescale 1ns / 100ps

module tb_levenshtein_edit_distance;

	localparam int unsigned MAX_LEN     = 64;
	localparam int unsigned RUN_ITEMS   = 1750;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned TEXT_MAX    = 80;

	// How a streamed query is closed.
	typedef enum int unsigned {
		CLOSE_LAST,
		CLOSE_EMPTY,
		CLOSE_NONE
	} close_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = '0;   // [7:0] char_code
	logic       s_axis_tlast = 1'b0;
	logic [1:0] s_axis_tuser = '0;   // [0] operation, [1] is_empty
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;        // [6:0] distance, [7] zero
	logic       m_axis_tuser;        // [0] too_long

	logic        calm = 1'b0;
	logic        hold_go = 1'b0;
	logic        hold_off = 1'b0;
	int unsigned cycles = 0;
	int unsigned sent = 0;
	logic [7:0]  ref_text [TEXT_MAX];
	int unsigned ref_size = 0;
	logic [7:0]  alpha [4];

	int errors;
	int pending;
	int items_seen;
	int results_seen;
	int long_results;

	levenshtein_edit_distance #(.MAX_LEN(MAX_LEN)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	levenshtein_checker #(.MAX_LEN(MAX_LEN)) distance_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending),
		.items_seen    (items_seen),
		.results_seen  (results_seen),
		.long_results  (long_results)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_off)
			m_axis_tready <= 1'b0;
		else if (calm)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= 17);
	end

	// Long result stall: the chain fills and the input side must back off.
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic offer_char(input led_pkg::op_t op, input logic [7:0] ch, input logic last,
			input logic empty);
		while (!calm && $urandom_range(0, 99) < 17) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tlast <= last;
		s_axis_tuser <= {empty, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		sent++;
		calm <= (sent >= 700 && sent < 1000);
	endtask

	function automatic int unsigned pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 0;
		if (r < 80)
			return $urandom_range(1, 12);
		if (r < 90)
			return $urandom_range(13, 40);
		if (r < 96)
			return MAX_LEN;
		return $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
	endfunction

	// A zero length loads an empty reference. Without fresh the characters extend
	// the reference already being built.
	task automatic load_reference(input int unsigned len, input bit fresh, input bit finish);
		int unsigned k;
		logic [7:0] ch;
		if (len == 0) begin
			offer_char(led_pkg::OP_LOAD, 8'($urandom), 1'($urandom), 1'b1);
			ref_size = 0;
			return;
		end
		if (fresh) begin
			ref_size = 0;
			for (k = 0; k < 4; k++)
				alpha[k] = 8'($urandom);
		end
		for (k = 0; k < len; k++) begin
			ch = alpha[$urandom_range(0, 3)];
			if (ref_size < TEXT_MAX)
				ref_text[ref_size] = ch;
			ref_size++;
			offer_char(led_pkg::OP_LOAD, ch, finish && k == len - 1, 1'b0);
		end
	endtask

	// With mutate set the query follows the reference with a few substitutions,
	// insertions and deletions, so that distances stay small and varied.
	task automatic stream_query(input int unsigned len, input close_t closing, input bit mutate);
		int unsigned k;
		int unsigned src;
		int unsigned r;
		logic [7:0] ch;
		if (len == 0) begin
			offer_char(led_pkg::OP_QUERY, 8'($urandom), 1'($urandom), 1'b1);
			return;
		end
		src = 0;
		for (k = 0; k < len; k++) begin
			r = $urandom_range(0, 99);
			if (mutate && src < ref_size && src < TEXT_MAX) begin
				if (r < 5 && src + 1 < ref_size && src + 1 < TEXT_MAX)
					src++;
				ch = (r >= 90) ? 8'($urandom) : ref_text[src];
				if (r < 5 || r >= 10)
					src++;
			end else
				ch = (r < 20) ? 8'($urandom) : alpha[$urandom_range(0, 3)];
			offer_char(led_pkg::OP_QUERY, ch, closing == CLOSE_LAST && k == len - 1, 1'b0);
		end
		if (closing == CLOSE_EMPTY)
			offer_char(led_pkg::OP_QUERY, 8'($urandom), 1'($urandom), 1'b1);
	endtask

	task automatic some_query();
		int len;
		close_t closing;
		closing = ($urandom_range(0, 99) < 8) ? CLOSE_EMPTY : CLOSE_LAST;
		if ($urandom_range(0, 1)) begin
			len = int'(ref_size) + int'($urandom_range(0, 4)) - 2;
			if (len < 1)
				len = 1;
			stream_query(unsigned'(len), closing, 1'b1);
		end else
			stream_query(pick_len(), closing, 1'b0);
	endtask

	initial begin
		int unsigned r;
		for (int k = 0; k < 4; k++)
			alpha[k] = 8'($urandom);
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Queries against the empty reference that reset leaves.
		offer_char(led_pkg::OP_QUERY, 8'hFF, 1'b0, 1'b1);
		offer_char(led_pkg::OP_QUERY, 8'h00, 1'b1, 1'b0);
		// Explicitly empty reference.
		offer_char(led_pkg::OP_LOAD, 8'hFF, 1'b1, 1'b1);
		offer_char(led_pkg::OP_QUERY, 8'hA5, 1'b1, 1'b0);
		// Two-character reference with the extreme byte values.
		offer_char(led_pkg::OP_LOAD, 8'h00, 1'b0, 1'b0);
		offer_char(led_pkg::OP_LOAD, 8'hFF, 1'b1, 1'b0);
		offer_char(led_pkg::OP_QUERY, 8'h00, 1'b0, 1'b0);
		offer_char(led_pkg::OP_QUERY, 8'hFF, 1'b1, 1'b0);
		offer_char(led_pkg::OP_QUERY, 8'hFF, 1'b1, 1'b0);
		// An empty query item closes a query already under way.
		offer_char(led_pkg::OP_QUERY, 8'h00, 1'b0, 1'b0);
		offer_char(led_pkg::OP_QUERY, 8'h5A, 1'b0, 1'b1);
		// A load abandons the open query and starts a new reference.
		offer_char(led_pkg::OP_QUERY, 8'h12, 1'b0, 1'b0);
		offer_char(led_pkg::OP_LOAD, 8'h34, 1'b1, 1'b0);
		offer_char(led_pkg::OP_QUERY, 8'h34, 1'b1, 1'b0);
		// Query against a reference that is not finished, which is then extended.
		offer_char(led_pkg::OP_LOAD, 8'h41, 1'b0, 1'b0);
		offer_char(led_pkg::OP_QUERY, 8'h41, 1'b1, 1'b0);
		offer_char(led_pkg::OP_LOAD, 8'h42, 1'b1, 1'b0);
		offer_char(led_pkg::OP_QUERY, 8'h42, 1'b1, 1'b0);
		offer_char(led_pkg::OP_QUERY, 8'h41, 1'b0, 1'b0);
		offer_char(led_pkg::OP_QUERY, 8'h42, 1'b1, 1'b0);

		// Over-length strings, with the result side stalled at first.
		load_reference(20, 1'b1, 1'b1);
		hold_go <= 1'b1;
		stream_query(MAX_LEN + 6, CLOSE_LAST, 1'b0);
		repeat (6)
			some_query();
		load_reference(MAX_LEN + 2, 1'b1, 1'b1);
		stream_query(MAX_LEN, CLOSE_LAST, 1'b1);
		stream_query(3, CLOSE_LAST, 1'b0);
		load_reference(MAX_LEN, 1'b1, 1'b1);
		stream_query(MAX_LEN + 1, CLOSE_LAST, 1'b1);
		stream_query(MAX_LEN + 2, CLOSE_EMPTY, 1'b0);

		while (sent < RUN_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				load_reference(pick_len(), 1'b1, 1'b1);
				repeat ($urandom_range(1, 4))
					some_query();
			end else if (r < 85) begin
				load_reference($urandom_range(1, 8), 1'b1, 1'b0);
				stream_query($urandom_range(1, 8), CLOSE_LAST, 1'b1);
				load_reference($urandom_range(1, 6), 1'b0, 1'b1);
				some_query();
			end else if (r < 92) begin
				stream_query($urandom_range(1, 10), CLOSE_NONE, $urandom_range(0, 1));
				load_reference(pick_len(), 1'b1, 1'b1);
				some_query();
			end else begin
				repeat ($urandom_range(1, 6))
					offer_char(led_pkg::op_t'($urandom_range(0, 1)), 8'($urandom),
						$urandom_range(0, 99) < 30, $urandom_range(0, 99) < 5);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (2 * MAX_LEN + 10) @(posedge clk);

		$display("Covered %0d input transfers and %0d distance results,",
			items_seen, results_seen);
		$display("%0d of them too long, with empty, unfinished, abandoned and %s %0d-cycle stall.",
			long_results, "over-length strings and a", HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
design/led_pkg.sv
design/led_cell.sv
design/levenshtein_edit_distance.sv
sim/levenshtein_checker.sv
sim/tb_levenshtein_edit_distance.sv
